>>> rtl/core/mvna_pkg.sv
package mvna_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int INDEX_BITS   = $clog2(MAX_VERTICES);
   localparam int COUNT_BITS   = INDEX_BITS + 1;
   localparam int COORD_BITS   = 24;
   localparam int NORMAL_BITS  = 16;
   localparam int SUM_BITS     = 56;
   localparam int EDGE_BITS    = COORD_BITS + 1;
   localparam int CROSS_BITS   = 2 * EDGE_BITS + 1;
   localparam int MUL_BITS     = 32;
   localparam int PROD_BITS    = 2 * MUL_BITS;
   localparam int NORM_BITS    = 31;
   localparam int LEN_BITS     = 32;
   // one extra bit for the rounding term added to the scaled magnitude
   localparam int NUM_BITS     = NORM_BITS + NORMAL_BITS + 1;
   localparam int SEL_BITS     = 3;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_FACE = 2'd1,
      OP_EMIT = 2'd2,
      OP_NOP  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic [INDEX_BITS-1:0]        vertex_index;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic [INDEX_BITS-1:0]        corner_a;
      logic [INDEX_BITS-1:0]        corner_b;
      logic [INDEX_BITS-1:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic signed [NORMAL_BITS-1:0] normal_x;
      logic signed [NORMAL_BITS-1:0] normal_y;
      logic signed [NORMAL_BITS-1:0] normal_z;
      logic [INDEX_BITS-1:0]         out_index;
      logic                          index_error;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_POS_RD, ST_POS_LAT, ST_EDGE, ST_MUL, ST_CROSS,
      ST_SUM_RD, ST_SUM_WR, ST_EMIT_RD, ST_MAG, ST_NORM, ST_SQ, ST_SQSUM, ST_SQRT,
      ST_DIV_INIT, ST_DIV, ST_DIV_DONE, ST_OUT
   } state_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_CAPTURE, DP_CLEAR, DP_LOAD, DP_POS_RD, DP_POS_LAT, DP_EDGE, DP_MUL,
      DP_CROSS, DP_SUM_RD, DP_SUM_WR, DP_EMIT_RD, DP_MAG, DP_SHIFT, DP_SQ, DP_SQSUM,
      DP_SQRT_STEP, DP_DIV_INIT, DP_DIV_STEP, DP_DIV_DONE, DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      logic [SEL_BITS-1:0]   sel;
      logic [INDEX_BITS-1:0] clr_addr;
   } cmd_type;

   typedef struct packed {
      logic need_right;
      logic need_left;
      logic skip_norm;
      logic out_free;
   } status_type;

endpackage

>>> rtl/core/mesh_vertex_normal_accumulate.sv
// Load: writes the position and zeroes the vertex's sum before the next ready.
// Face: three position reads, six passes through the one shared multiplier and three
// read-modify-writes of the sum memories. Emit: a zero sum or a flagged index goes
// straight to the result; otherwise it runs the normalizing shift, one bit per
// cycle, then the square root and three divides.
// Reset is synchronous; afterwards a clearing pass zeroes all 4096 entries of the sum
// memories with req_ready low. A waiting result does not block loads and faces.
module mesh_vertex_normal_accumulate (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  mvna_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output mvna_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [mvna_pkg::COUNT_BITS-1:0] csr_wr_data
);
   import mvna_pkg::*;

   cmd_type    cmd;
   status_type status;

   mvna_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .status     (status),
      .req_ready  (req_ready),
      .cmd        (cmd)
   );

   mvna_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.index_error |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("index error result carries a nonzero normal");

   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("input ready during the sum clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode != OP_NOP |=> !req_ready)
      else $error("new transaction taken while one is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result transaction changed while waiting");

endmodule

>>> rtl/core/mvna_ctrl.sv
module mvna_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_opcode,
   input  mvna_pkg::status_type    status,
   output logic                    req_ready,
   output mvna_pkg::cmd_type       cmd
);
   import mvna_pkg::*;

   localparam int CNT_BITS = INDEX_BITS;
   localparam logic [CNT_BITS-1:0] CLEAR_LAST = CNT_BITS'(MAX_VERTICES - 1);
   localparam logic [CNT_BITS-1:0] CORNER_LAST = CNT_BITS'(2);
   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(5);
   localparam logic [CNT_BITS-1:0] SQRT_LAST = CNT_BITS'(PROD_BITS / 2 - 1);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(NORMAL_BITS - 1);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [1:0]            comp_ff, comp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CLEAR_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (opcode_type'(req_opcode))
                  OP_LOAD: state_in = ST_LOAD;
                  OP_FACE: state_in = ST_POS_RD;
                  OP_EMIT: state_in = ST_EMIT_RD;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD:    state_in = ST_IDLE;
         ST_POS_RD:  state_in = ST_POS_LAT;
         ST_POS_LAT: begin
            if (cnt_ff == CORNER_LAST) begin
               cnt_in   = '0;
               state_in = ST_EDGE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_POS_RD;
            end
         end
         ST_EDGE: state_in = ST_MUL;
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_CROSS;
            end
         end
         ST_CROSS:  state_in = ST_SUM_RD;
         ST_SUM_RD: state_in = ST_SUM_WR;
         ST_SUM_WR: begin
            if (cnt_ff == CORNER_LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_SUM_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_MAG;
         ST_MAG:     state_in = ST_NORM;
         ST_NORM: begin
            if (status.skip_norm) begin
               state_in = ST_OUT;
            end else if (!status.need_right && !status.need_left) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CORNER_LAST) begin
               cnt_in   = '0;
               state_in = ST_SQSUM;
            end
         end
         ST_SQSUM: state_in = ST_SQRT;
         ST_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            if (comp_ff == 2'd2) begin
               comp_in  = '0;
               state_in = ST_OUT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_DIV_INIT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.op       = DP_NOP;
      cmd.sel      = cnt_ff[SEL_BITS-1:0];
      cmd.clr_addr = cnt_ff;
      case (state_ff)
         ST_CLEAR: cmd.op = DP_CLEAR;
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_CAPTURE;
            end
         end
         ST_LOAD:     cmd.op = DP_LOAD;
         ST_POS_RD:   cmd.op = DP_POS_RD;
         ST_POS_LAT:  cmd.op = DP_POS_LAT;
         ST_EDGE:     cmd.op = DP_EDGE;
         ST_MUL:      cmd.op = DP_MUL;
         ST_CROSS:    cmd.op = DP_CROSS;
         ST_SUM_RD:   cmd.op = DP_SUM_RD;
         ST_SUM_WR:   cmd.op = DP_SUM_WR;
         ST_EMIT_RD:  cmd.op = DP_EMIT_RD;
         ST_MAG:      cmd.op = DP_MAG;
         ST_NORM: begin
            if (!status.skip_norm && (status.need_right || status.need_left)) begin
               cmd.op = DP_SHIFT;
            end
         end
         ST_SQ:       cmd.op = DP_SQ;
         ST_SQSUM:    cmd.op = DP_SQSUM;
         ST_SQRT:     cmd.op = DP_SQRT_STEP;
         ST_DIV_INIT: begin
            cmd.op  = DP_DIV_INIT;
            cmd.sel = SEL_BITS'(comp_ff);
         end
         ST_DIV:      cmd.op = DP_DIV_STEP;
         ST_DIV_DONE: begin
            cmd.op  = DP_DIV_DONE;
            cmd.sel = SEL_BITS'(comp_ff);
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.op = DP_OUT;
            end
         end
         default: cmd.op = DP_NOP;
      endcase
   end

endmodule

>>> rtl/core/mvna_dp.sv
module mvna_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  mvna_pkg::req_type             req_data,
   input  logic                          csr_wr_en,
   input  logic [mvna_pkg::COUNT_BITS-1:0] csr_wr_data,
   input  mvna_pkg::cmd_type             cmd,
   output mvna_pkg::status_type          status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mvna_pkg::rsp_type             rsp_data
);
   import mvna_pkg::*;

   localparam int MAG_BITS = SUM_BITS;

   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0]   s,
      input logic signed [CROSS_BITS-1:0] n
   );
      logic signed [SUM_BITS:0] t;
      t = {s[SUM_BITS-1], s} + (SUM_BITS+1)'(n);
      if (t[SUM_BITS] != t[SUM_BITS-1]) begin
         sat_add = t[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sat_add = t[SUM_BITS-1:0];
      end
   endfunction

   req_type                         req_ff;
   logic [COUNT_BITS-1:0]           vcount_ff;

   logic signed [COORD_BITS-1:0]    pos_x_mem [MAX_VERTICES];
   logic signed [COORD_BITS-1:0]    pos_y_mem [MAX_VERTICES];
   logic signed [COORD_BITS-1:0]    pos_z_mem [MAX_VERTICES];
   logic signed [SUM_BITS-1:0]      sum_x_mem [MAX_VERTICES];
   logic signed [SUM_BITS-1:0]      sum_y_mem [MAX_VERTICES];
   logic signed [SUM_BITS-1:0]      sum_z_mem [MAX_VERTICES];

   logic signed [COORD_BITS-1:0]    pos_rd_ff [3];
   logic signed [SUM_BITS-1:0]      sum_rd_ff [3];
   logic signed [COORD_BITS-1:0]    px_ff [3];
   logic signed [COORD_BITS-1:0]    py_ff [3];
   logic signed [COORD_BITS-1:0]    pz_ff [3];
   logic signed [EDGE_BITS-1:0]     e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [PROD_BITS-1:0]     prod_ff [6];
   logic signed [CROSS_BITS-1:0]    n_ff [3];
   logic [MAG_BITS-1:0]             mag_ff [3];
   logic [MAG_BITS-1:0]             mx_ff;
   logic [2:0]                      neg_ff;
   logic                            err_ff, skip_ff;
   logic [PROD_BITS-1:0]            rad_ff, root_ff, bit_ff;
   logic [LEN_BITS-1:0]             rem_ff;
   logic [NORMAL_BITS-1:0]          low_ff, quo_ff;
   logic signed [NORMAL_BITS-1:0]   res_ff [3];
   logic                            rsp_valid_ff;
   rsp_type                         rsp_ff;

   logic [INDEX_BITS-1:0]           corner;
   logic [INDEX_BITS-1:0]           sum_wr_addr, sum_rd_addr;
   logic                            sum_wr_en;
   logic signed [SUM_BITS-1:0]      sum_wr_x, sum_wr_y, sum_wr_z;
   logic signed [MUL_BITS-1:0]      mul_a, mul_b;
   logic [PROD_BITS-1:0]            root_try;
   logic [LEN_BITS-1:0]             len;
   logic [NUM_BITS-1:0]             num;
   logic [LEN_BITS:0]               div_try;
   logic [MAG_BITS-1:0]             mag_new [3];
   logic [1:0]                      csel;

   assign csel = cmd.sel[1:0];

   always_comb begin
      case (csel)
         2'd0:    corner = req_ff.corner_a;
         2'd1:    corner = req_ff.corner_b;
         default: corner = req_ff.corner_c;
      endcase
   end

   always_comb begin
      sum_wr_en   = 1'b0;
      sum_wr_addr = corner;
      sum_wr_x    = '0;
      sum_wr_y    = '0;
      sum_wr_z    = '0;
      case (cmd.op)
         DP_CLEAR: begin
            sum_wr_en   = 1'b1;
            sum_wr_addr = cmd.clr_addr;
         end
         DP_LOAD: begin
            sum_wr_en   = 1'b1;
            sum_wr_addr = req_ff.vertex_index;
         end
         DP_SUM_WR: begin
            sum_wr_en = 1'b1;
            sum_wr_x  = sat_add(sum_rd_ff[0], n_ff[0]);
            sum_wr_y  = sat_add(sum_rd_ff[1], n_ff[1]);
            sum_wr_z  = sat_add(sum_rd_ff[2], n_ff[2]);
         end
         default: sum_wr_en = 1'b0;
      endcase
   end

   assign sum_rd_addr = (cmd.op == DP_EMIT_RD) ? req_ff.vertex_index : corner;

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         pos_x_mem[req_ff.vertex_index] <= req_ff.pos_x;
         pos_y_mem[req_ff.vertex_index] <= req_ff.pos_y;
         pos_z_mem[req_ff.vertex_index] <= req_ff.pos_z;
      end
      if (cmd.op == DP_POS_RD) begin
         pos_rd_ff[0] <= pos_x_mem[corner];
         pos_rd_ff[1] <= pos_y_mem[corner];
         pos_rd_ff[2] <= pos_z_mem[corner];
      end
   end

   always_ff @(posedge clock) begin
      if (sum_wr_en) begin
         sum_x_mem[sum_wr_addr] <= sum_wr_x;
         sum_y_mem[sum_wr_addr] <= sum_wr_y;
         sum_z_mem[sum_wr_addr] <= sum_wr_z;
      end
      if (cmd.op == DP_SUM_RD || cmd.op == DP_EMIT_RD) begin
         sum_rd_ff[0] <= sum_x_mem[sum_rd_addr];
         sum_rd_ff[1] <= sum_y_mem[sum_rd_addr];
         sum_rd_ff[2] <= sum_z_mem[sum_rd_addr];
      end
   end

   // shared multiplier: cross terms for faces, squares for emits
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.op == DP_SQ) begin
         mul_a = MUL_BITS'(mag_ff[csel][NORM_BITS-1:0]);
         mul_b = mul_a;
      end else begin
         case (cmd.sel)
            3'd0:    begin mul_a = MUL_BITS'(e1y_ff); mul_b = MUL_BITS'(e2z_ff); end
            3'd1:    begin mul_a = MUL_BITS'(e1z_ff); mul_b = MUL_BITS'(e2y_ff); end
            3'd2:    begin mul_a = MUL_BITS'(e1z_ff); mul_b = MUL_BITS'(e2x_ff); end
            3'd3:    begin mul_a = MUL_BITS'(e1x_ff); mul_b = MUL_BITS'(e2z_ff); end
            3'd4:    begin mul_a = MUL_BITS'(e1x_ff); mul_b = MUL_BITS'(e2y_ff); end
            default: begin mul_a = MUL_BITS'(e1y_ff); mul_b = MUL_BITS'(e2x_ff); end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_new[i] = sum_rd_ff[i][SUM_BITS-1] ? MAG_BITS'(-sum_rd_ff[i])
                                                : MAG_BITS'(sum_rd_ff[i]);
      end
   end

   assign root_try = root_ff + bit_ff;
   assign len      = root_ff[LEN_BITS-1:0];
   assign num      = NUM_BITS'({mag_ff[csel][NORM_BITS-1:0], {(NORMAL_BITS-1){1'b0}}})
                     + NUM_BITS'(len >> 1);
   assign div_try  = {rem_ff, low_ff[NORMAL_BITS-1]};

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_CAPTURE: req_ff <= req_data;
         DP_POS_LAT: begin
            px_ff[csel] <= pos_rd_ff[0];
            py_ff[csel] <= pos_rd_ff[1];
            pz_ff[csel] <= pos_rd_ff[2];
         end
         DP_EDGE: begin
            e1x_ff <= EDGE_BITS'(px_ff[1]) - EDGE_BITS'(px_ff[0]);
            e1y_ff <= EDGE_BITS'(py_ff[1]) - EDGE_BITS'(py_ff[0]);
            e1z_ff <= EDGE_BITS'(pz_ff[1]) - EDGE_BITS'(pz_ff[0]);
            e2x_ff <= EDGE_BITS'(px_ff[2]) - EDGE_BITS'(px_ff[0]);
            e2y_ff <= EDGE_BITS'(py_ff[2]) - EDGE_BITS'(py_ff[0]);
            e2z_ff <= EDGE_BITS'(pz_ff[2]) - EDGE_BITS'(pz_ff[0]);
         end
         DP_MUL, DP_SQ: prod_ff[cmd.sel] <= mul_a * mul_b;
         DP_CROSS: begin
            n_ff[0] <= CROSS_BITS'(prod_ff[0] - prod_ff[1]);
            n_ff[1] <= CROSS_BITS'(prod_ff[2] - prod_ff[3]);
            n_ff[2] <= CROSS_BITS'(prod_ff[4] - prod_ff[5]);
         end
         DP_MAG: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_new[i];
               neg_ff[i] <= sum_rd_ff[i][SUM_BITS-1];
            end
            mx_ff   <= mag_new[0] | mag_new[1] | mag_new[2];
            err_ff  <= COUNT_BITS'(req_ff.vertex_index) >= vcount_ff;
            skip_ff <= (COUNT_BITS'(req_ff.vertex_index) >= vcount_ff)
                       || ((mag_new[0] | mag_new[1] | mag_new[2]) == '0);
         end
         DP_SHIFT: begin
            // right shifts truncate, matching one combined shift
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= status.need_right ? mag_ff[i] >> 1 : mag_ff[i] << 1;
            end
            mx_ff <= status.need_right ? mx_ff >> 1 : mx_ff << 1;
         end
         DP_SQSUM: begin
            rad_ff  <= PROD_BITS'(prod_ff[0]) + PROD_BITS'(prod_ff[1])
                       + PROD_BITS'(prod_ff[2]);
            root_ff <= '0;
            bit_ff  <= PROD_BITS'(1) << (PROD_BITS - 2);
         end
         DP_SQRT_STEP: begin
            if (rad_ff >= root_try) begin
               rad_ff  <= rad_ff - root_try;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         DP_DIV_INIT: begin
            rem_ff <= LEN_BITS'(num[NUM_BITS-1:NORMAL_BITS]);
            low_ff <= num[NORMAL_BITS-1:0];
            quo_ff <= '0;
         end
         DP_DIV_STEP: begin
            if (div_try >= (LEN_BITS+1)'(len)) begin
               rem_ff <= LEN_BITS'(div_try - (LEN_BITS+1)'(len));
               quo_ff <= {quo_ff[NORMAL_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= div_try[LEN_BITS-1:0];
               quo_ff <= {quo_ff[NORMAL_BITS-2:0], 1'b0};
            end
            low_ff <= low_ff << 1;
         end
         DP_DIV_DONE: begin
            if (neg_ff[csel]) begin
               res_ff[csel] <= -quo_ff;
            end else if (quo_ff[NORMAL_BITS-1]) begin
               res_ff[csel] <= {1'b0, {(NORMAL_BITS-1){1'b1}}};
            end else begin
               res_ff[csel] <= quo_ff;
            end
         end
         DP_OUT: begin
            rsp_ff.normal_x    <= skip_ff ? '0 : res_ff[0];
            rsp_ff.normal_y    <= skip_ff ? '0 : res_ff[1];
            rsp_ff.normal_z    <= skip_ff ? '0 : res_ff[2];
            rsp_ff.out_index   <= req_ff.vertex_index;
            rsp_ff.index_error <= err_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            vcount_ff <= csr_wr_data;
         end
         if (cmd.op == DP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.need_right = |mx_ff[MAG_BITS-1:NORM_BITS];
   assign status.need_left  = !mx_ff[NORM_BITS-1] && !status.need_right;
   assign status.skip_norm  = skip_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
